/* hw/rtl/ipv4_tunnel_encapsulator_top_assert.svh */
// assertion macros used by the checker file
`ifndef IPV4_TUNNEL_ENCAPSULATOR_TOP_ASSERT_SVH
`define IPV4_TUNNEL_ENCAPSULATOR_TOP_ASSERT_SVH

// property checked outside reset
`define ITE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define ITE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/ite_pkg.sv */
package ite_pkg;

   localparam int HDR_BYTES  = 20;
   localparam int NUM_MATCH  = 7;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_WORDS  = 5;
   localparam int WORD_IDX_W = 3;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET = 3'd7;
   localparam logic [7:0] VER_IHL    = 8'h45;
   localparam logic [7:0] PROTO_IPIP = 8'h04;

   localparam logic [31:0] REG_RESET [NUM_REGS] = '{
      32'h4039174A, 32'h4039174B, 32'h40391742, 32'h40391743,
      32'hAB184A69, 32'hAB184A6A, 32'h7F000001, 32'h4039174A
   };

   typedef enum logic [1:0] {
      ACT_PASS = 2'd0,
      ACT_WORD = 2'd1,
      ACT_DROP = 2'd2
   } ite_action_type;

   typedef struct packed {
      logic        has_header;
      logic [31:0] dest_addr;
      logic [31:0] src_addr;
      logic [7:0]  service_type;
      logic [15:0] ident;
      logic [7:0]  hop_limit;
      logic [15:0] packet_length;
      logic [15:0] spare_room;
   } ite_req_type;

   typedef struct packed {
      ite_action_type action;
      logic [31:0]    header_word;
      logic           last_word;
   } ite_rsp_type;

   // classified packet, everything the back end needs to emit it
   typedef struct packed {
      ite_action_type action;
      logic [7:0]     service_type;
      logic [15:0]    total_len;
      logic [15:0]    ident;
      logic [7:0]     hop_limit;
      logic [15:0]    check;
      logic [31:0]    src_addr;
      logic [31:0]    tgt_addr;
   } ite_desc_type;

   function automatic logic [31:0] hdr_word(ite_desc_type d, logic [WORD_IDX_W-1:0] idx);
      logic [31:0] w;
      case (idx)
         3'd0: w = {VER_IHL, d.service_type, d.total_len};
         3'd1: w = {d.ident, 16'h0000};
         3'd2: w = {d.hop_limit, PROTO_IPIP, d.check};
         3'd3: w = d.src_addr;
         default: w = d.tgt_addr;
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/ite_front.sv */
module ite_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ite_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata,
   input  logic                           req_push,
   input  ite_pkg::ite_req_type           req_data,
   output logic                           req_full,
   output logic                           desc_vld,
   output ite_pkg::ite_desc_type          desc_data,
   input  logic                           desc_full
);
   import ite_pkg::*;

   logic [31:0]    cfg_ff [NUM_REGS];

   logic           s1_vld_ff, s1_vld_in;
   ite_desc_type   s1_desc_ff, s1_desc_in;
   logic [17:0]    s1_suma_ff, s1_suma_in;
   logic [17:0]    s1_sumb_ff, s1_sumb_in;

   logic           s2_vld_ff, s2_vld_in;
   ite_desc_type   s2_desc_ff, s2_desc_in;

   logic           s1_rdy, s2_rdy, accept, hit, drop;
   logic [16:0]    total17;
   logic [18:0]    sum;
   logic [16:0]    fold1;
   logic [15:0]    fold2;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= REG_RESET[i];
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   assign s2_rdy   = !s2_vld_ff || !desc_full;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign req_full = !s1_rdy;
   assign accept   = req_push && s1_rdy;

   // stage 1: address match, room and length checks, partial checksums
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_MATCH; i++) begin
         if (cfg_ff[i] == req_data.dest_addr) hit = 1'b1;
      end
      total17 = {1'b0, req_data.packet_length} + 17'(HDR_BYTES);
      drop    = (req_data.spare_room < 16'(HDR_BYTES)) || total17[16];

      s1_desc_in.service_type = req_data.service_type;
      s1_desc_in.total_len    = total17[15:0];
      s1_desc_in.ident        = req_data.ident;
      s1_desc_in.hop_limit    = req_data.hop_limit;
      s1_desc_in.check        = 16'h0000;
      s1_desc_in.src_addr     = req_data.src_addr;
      s1_desc_in.tgt_addr     = cfg_ff[REG_TARGET];
      if (!req_data.has_header || !hit) begin
         s1_desc_in.action = ACT_PASS;
      end else if (drop) begin
         s1_desc_in.action = ACT_DROP;
      end else begin
         s1_desc_in.action = ACT_WORD;
      end

      s1_suma_in = 18'({VER_IHL, req_data.service_type}) + 18'(total17[15:0])
                 + 18'(req_data.ident) + 18'({req_data.hop_limit, PROTO_IPIP});
      s1_sumb_in = 18'(req_data.src_addr[31:16]) + 18'(req_data.src_addr[15:0])
                 + 18'(cfg_ff[REG_TARGET][31:16]) + 18'(cfg_ff[REG_TARGET][15:0]);
   end

   assign s1_vld_in = s1_rdy ? accept : 1'b1;

   // stage 2: end-around carry fold and complement
   always_comb begin
      sum   = 19'(s1_suma_ff) + 19'(s1_sumb_ff);
      fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      s2_desc_in       = s1_desc_ff;
      s2_desc_in.check = ~fold2;
   end

   assign s2_vld_in = s2_rdy ? s1_vld_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_desc_ff <= s1_desc_in;
         s1_suma_ff <= s1_suma_in;
         s1_sumb_ff <= s1_sumb_in;
      end
      if (s2_rdy) begin
         s2_desc_ff <= s2_desc_in;
      end
   end

   assign desc_vld  = s2_vld_ff;
   assign desc_data = s2_desc_ff;

endmodule

/* hw/rtl/ite_queue.sv */
module ite_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ite_pkg::ite_desc_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output ite_pkg::ite_desc_type head_data
);
   import ite_pkg::*;

   ite_desc_type       slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];

endmodule

/* hw/rtl/ite_back.sv */
module ite_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  ite_pkg::ite_desc_type q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   output ite_pkg::ite_rsp_type  rsp_data,
   input  logic                  rsp_pop
);
   import ite_pkg::*;

   localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(NUM_WORDS - 1);

   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   ite_rsp_type           rsp_ff, rsp_in;
   logic                  load, take, last;

   // output register refills from the queue head whenever it is empty or being drained
   assign load = !rsp_vld_ff || rsp_pop;
   assign take = load && !q_empty;
   assign last = (q_head.action != ACT_WORD) || (idx_ff == LAST_IDX);

   assign q_pop = take && last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
      rsp_vld_in = take ? 1'b1 : (load ? 1'b0 : rsp_vld_ff);

      rsp_in.action      = q_head.action;
      rsp_in.header_word = (q_head.action == ACT_WORD) ? hdr_word(q_head, idx_ff) : 32'h0;
      rsp_in.last_word   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/ipv4_tunnel_encapsulator_top.sv */
// IPv4 IP-in-IP tunnel header generator.
// req_ side: one packet descriptor per item, pushed with req_push while req_full is low.
// rsp_ side: results are read like a queue; the head item sits on rsp_data while
//   rsp_empty is low and leaves on rsp_pop. A packet that passes or is dropped gives one
//   item; an encapsulated packet gives five outer header words, the fifth marked last_word.
// csr_ side: eight 32-bit registers (seven match addresses, then the tunnel target),
//   written with csr_we, csr_index and csr_wdata; write only while the block is idle.
// Path: an accepted item passes two classify/checksum stages, then a 4-entry descriptor
//   queue, then the output register.
// Throughput: one pass or drop item per cycle while rsp_pop keeps draining the output;
//   an encapsulated packet feeds its words through the one-word output register one at a time.
// Reset: clears the pipeline, the queue and the output register and reloads the register
//   defaults; req_full is low and rsp_empty high right after reset.
// Stall: when rsp_pop stays low the head result holds, the queue fills and then req_full
//   rises; no item is lost and accepting resumes once the queue frees an entry.
module ipv4_tunnel_encapsulator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ite_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic                          req_push,
   input  ite_pkg::ite_req_type          req_data,
   output logic                          req_full,
   output logic                          rsp_empty,
   output ite_pkg::ite_rsp_type          rsp_data,
   input  logic                          rsp_pop
);
   import ite_pkg::*;

   logic         desc_vld, q_full, q_empty, q_pop;
   ite_desc_type desc_data, q_head;

   ite_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .desc_vld  (desc_vld),
      .desc_data (desc_data),
      .desc_full (q_full)
   );

   ite_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_vld),
      .push_data (desc_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head)
   );

   ite_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

/* hw/rtl/ite_checker.sv */
`include "ipv4_tunnel_encapsulator_top_assert.svh"

module ite_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input ite_pkg::ite_rsp_type rsp_data,
   input logic                 rsp_pop
);
   import ite_pkg::*;

   // leaving reset the block is empty and open for items
   `ITE_ASSERT_ALWAYS(a_reset_idle,
      (!reset && $past(reset)) |-> (rsp_empty && !req_full),
      "not idle after reset")

   // pass and drop are single, zero-filled, final items
   `ITE_ASSERT(a_single_result,
      (!rsp_empty && rsp_data.action != ACT_WORD) |->
         (rsp_data.last_word && rsp_data.header_word == 32'h0),
      "pass or drop item not single")

   // header words of one packet follow each other with no gap
   `ITE_ASSERT(a_header_burst,
      (!rsp_empty && rsp_pop && rsp_data.action == ACT_WORD && !rsp_data.last_word) |=>
         (!rsp_empty && rsp_data.action == ACT_WORD),
      "header burst broken")

   // a result that is not taken holds
   `ITE_ASSERT(a_rsp_hold,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)),
      "result changed while stalled")

endmodule

bind ipv4_tunnel_encapsulator_top ite_checker u_ite_checker (.*);
